// File: rtl/core/mfps_pkg.sv
// ----------------------------------------------------------------------------
// mfps_pkg: shared constants and types for the falling path sum block
// Field widths, register indexes and the control bundle of the cost chain.
// ----------------------------------------------------------------------------
`default_nettype none

package mfps_pkg;

    localparam int unsigned MAX_COLS_DEF = 64;
    localparam int unsigned MAX_ROWS_DEF = 64;

    localparam int unsigned SIZE_W    = 7;   // grid_rows / grid_cols
    localparam int unsigned VAL_W     = 8;   // cell_value
    localparam int unsigned COST_W    = 14;  // path costs, min_sum
    localparam int unsigned COL_OUT_W = 6;   // end_column
    localparam int unsigned IN_W      = 8;   // s_tdata
    localparam int unsigned OUT_W     = 24;  // m_tdata

    localparam logic [COST_W-1:0] COST_MAX = '1;

    // register indexes
    localparam logic REG_GRID_ROWS = 1'b0;
    localparam logic REG_GRID_COLS = 1'b1;

    // Broadcast to every stage of the cost chain
    typedef struct packed {
        logic              en;    // shift by one
        logic [SIZE_W-1:0] tail;  // stage that loads the new cost
        logic [COST_W-1:0] cost;  // cost of the cell just taken
    } shift_t;

endpackage

`default_nettype wire

// File: rtl/core/mfps_cell.sv
// ----------------------------------------------------------------------------
// mfps_cell: one stage of the row cost chain
// Holds one stored cost; loads the new cost when it is the tail of the
// chain, otherwise takes the cost of its right-hand neighbour.
// ----------------------------------------------------------------------------
`default_nettype none

module mfps_cell #(
    parameter int unsigned INDEX = 0
) (
    input  wire logic                         clk,
    input  wire mfps_pkg::shift_t             ctl,
    input  wire logic [mfps_pkg::COST_W-1:0]  from_right,
    output logic      [mfps_pkg::COST_W-1:0]  cost
);

    localparam logic [mfps_pkg::SIZE_W-1:0] MY_INDEX = INDEX[mfps_pkg::SIZE_W-1:0];

    logic [mfps_pkg::COST_W-1:0] cost_reg;
    logic [mfps_pkg::COST_W-1:0] cost_next;

    always_comb
    begin
        cost_next = (ctl.tail == MY_INDEX) ? ctl.cost : from_right;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            cost_reg <= cost_next;
        end
    end

    assign cost = cost_reg;

endmodule

`default_nettype wire

// File: rtl/core/min_falling_path_sum_top.sv
// ----------------------------------------------------------------------------
// min_falling_path_sum_top: minimum falling path sum over a streamed grid
// The result is registered and appears in the cycle after a grid's last cell.
// Throughput: one cell per cycle while no result is stalled; the cost chain
// shifts once per item; its head holds the next cell's up and up-right costs.
// Reset: asynchronous, active low; sizes return to 1 by 1, grid restarts.
// A configuration write also restarts the grid in progress.
// ----------------------------------------------------------------------------
`default_nettype none

module min_falling_path_sum_top #(
    parameter int unsigned MAX_COLS = mfps_pkg::MAX_COLS_DEF,
    parameter int unsigned MAX_ROWS = mfps_pkg::MAX_ROWS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // config port
    input  wire logic                           cfg_we,
    input  wire logic                           cfg_index,
    input  wire logic [mfps_pkg::SIZE_W-1:0]    cfg_data,
    // input stream
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [mfps_pkg::IN_W-1:0]      s_tdata,   // [7:0] cell_value
    // result stream
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [mfps_pkg::OUT_W-1:0]     m_tdata    // [13:0] min_sum,
                                                           // [19:14] end_column
);

    localparam int unsigned SW = mfps_pkg::SIZE_W;
    localparam int unsigned CW = mfps_pkg::COST_W;
    localparam int unsigned SIZE_CAP = (1 << SW) - 1;
    localparam int unsigned COLS_CAP = (MAX_COLS < SIZE_CAP) ? MAX_COLS : SIZE_CAP;
    localparam int unsigned ROWS_CAP = (MAX_ROWS < SIZE_CAP) ? MAX_ROWS : SIZE_CAP;
    localparam logic [SW-1:0] COLS_LIM = COLS_CAP[SW-1:0];
    localparam logic [SW-1:0] ROWS_LIM = ROWS_CAP[SW-1:0];
    localparam int unsigned NCELL  = COLS_CAP;
    localparam int unsigned UR_IDX = (NCELL > 1) ? 1 : 0;
    localparam int unsigned PAD_W  = mfps_pkg::OUT_W - CW - mfps_pkg::COL_OUT_W;

    logic [SW-1:0] grid_rows_reg;
    logic [SW-1:0] grid_cols_reg;
    logic [SW-1:0] row_reg;
    logic [SW-1:0] col_reg;
    logic [CW-1:0] best_reg;
    logic [SW-1:0] best_col_reg;
    logic [CW-1:0] left_cost_reg;
    logic          out_valid_reg;
    logic [CW-1:0] out_sum_reg;
    logic [mfps_pkg::COL_OUT_W-1:0] out_col_reg;

    logic [SW-1:0] eff_rows;
    logic [SW-1:0] eff_cols;
    logic          accept;
    logic          last_col;
    logic          last_row;
    logic          has_right;
    logic [CW-1:0] val_ext;
    logic [CW-1:0] above;
    logic [CW:0]   sum;
    logic [CW-1:0] cost;
    logic [CW-1:0] best_next;
    logic [SW-1:0] best_col_next;

    mfps_pkg::shift_t ctl;
    logic [CW-1:0]    chain [NCELL];

    // zero acts as one, too large acts as the maximum
    always_comb
    begin
        eff_rows = (grid_rows_reg == '0) ? SW'(1)
                 : ((grid_rows_reg > ROWS_LIM) ? ROWS_LIM : grid_rows_reg);
        eff_cols = (grid_cols_reg == '0) ? SW'(1)
                 : ((grid_cols_reg > COLS_LIM) ? COLS_LIM : grid_cols_reg);
    end

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        last_col  = ({1'b0, col_reg} + (SW+1)'(1)) >= {1'b0, eff_cols};
        last_row  = ({1'b0, row_reg} + (SW+1)'(1)) >= {1'b0, eff_rows};
        has_right = !last_col;
        val_ext   = {{(CW - mfps_pkg::VAL_W){1'b0}}, s_tdata[mfps_pkg::VAL_W-1:0]};

        // head of chain: up, one to its right: up-right, left_cost_reg: up-left
        above = chain[0];
        if ((col_reg != '0) && (left_cost_reg < above))
        begin
            above = left_cost_reg;
        end
        if (has_right && (chain[UR_IDX] < above))
        begin
            above = chain[UR_IDX];
        end

        sum = {1'b0, val_ext} + {1'b0, above};
        if (row_reg == '0)
        begin
            cost = val_ext;
        end
        else
        begin
            cost = sum[CW] ? mfps_pkg::COST_MAX : sum[CW-1:0];
        end

        best_next     = best_reg;
        best_col_next = best_col_reg;
        if (last_row && ((col_reg == '0) || (cost < best_reg)))
        begin
            best_next     = cost;
            best_col_next = col_reg;
        end
    end

    always_comb
    begin
        ctl.en   = accept;
        ctl.tail = eff_cols - SW'(1);
        ctl.cost = cost;
    end

    // chain of cost stages, shifting toward stage 0
    for (genvar k = 0; k < NCELL; k++)
    begin : g_cell
        logic [CW-1:0] from_right;
        if (k == NCELL - 1)
        begin : g_end
            assign from_right = cost;
        end
        else
        begin : g_mid
            assign from_right = chain[k+1];
        end
        mfps_cell #(
            .INDEX (k)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .from_right (from_right),
            .cost       (chain[k])
        );
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            left_cost_reg <= chain[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg <= SW'(1);
            grid_cols_reg <= SW'(1);
            row_reg       <= '0;
            col_reg       <= '0;
            best_reg      <= mfps_pkg::COST_MAX;
            best_col_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mfps_pkg::REG_GRID_ROWS: grid_rows_reg <= cfg_data;
                mfps_pkg::REG_GRID_COLS: grid_cols_reg <= cfg_data;
                default: ;
            endcase
            row_reg      <= '0;
            col_reg      <= '0;
            best_reg     <= mfps_pkg::COST_MAX;
            best_col_reg <= '0;
        end
        else if (accept)
        begin
            if (!last_col)
            begin
                col_reg      <= col_reg + SW'(1);
                best_reg     <= best_next;
                best_col_reg <= best_col_next;
            end
            else if (!last_row)
            begin
                col_reg      <= '0;
                row_reg      <= row_reg + SW'(1);
                best_reg     <= best_next;
                best_col_reg <= best_col_next;
            end
            else
            begin
                col_reg      <= '0;
                row_reg      <= '0;
                best_reg     <= mfps_pkg::COST_MAX;
                best_col_reg <= '0;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept && !cfg_we && last_col && last_row)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && last_col && last_row)
        begin
            out_sum_reg <= best_next;
            out_col_reg <= best_col_next[mfps_pkg::COL_OUT_W-1:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_col_reg, out_sum_reg};

endmodule

`default_nettype wire

// File: rtl/core/mfps_checker.sv
// ----------------------------------------------------------------------------
// mfps_checker: port-level checks for the falling path sum block
// Watches the stream handshakes and the config port of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mfps_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        cfg_we,
    input wire logic                        s_tvalid,
    input wire logic                        s_tready,
    input wire logic                        m_tvalid,
    input wire logic                        m_tready,
    input wire logic [mfps_pkg::OUT_W-1:0]  m_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // a waiting result blocks further input
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while result stalled");

    // a result only follows an accepted item
    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready))
        else $error("result without an item");

    // a config write restarts the grid, so no result follows it
    a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> !$rose(m_tvalid))
        else $error("result right after config write");

endmodule

bind min_falling_path_sum_top mfps_checker u_mfps_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
